// ===== hdl/slmc_pkg.sv =====
package slmc_pkg;

    localparam int MAX_SIDE   = 32;
    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int SIZE_W     = 6;
    localparam int SIZE_RESET = 8;
    localparam int DATA_W     = 16;
    localparam int CNT_W      = 11;
    localparam int DEPTH      = 3 * MAX_SIDE;
    localparam int ADDR_W     = $clog2(DEPTH);

    typedef logic [1:0] t_slot;

    localparam t_slot SLOT_0 = 2'd0;
    localparam t_slot SLOT_1 = 2'd1;
    localparam t_slot SLOT_2 = 2'd2;

    // one decision handed to the neighborhood scanner
    typedef struct packed {
        logic [POS_W-1:0] row;
        t_slot            slot;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] n_m1;
        logic             last;
    } t_scan_req;

    // finished decision waiting to be taken
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              flag;
        logic              last;
    } t_scan_res;

    function automatic t_slot slot_next(t_slot s);
        t_slot r;
        case (s)
            SLOT_0:  r = SLOT_1;
            SLOT_1:  r = SLOT_2;
            default: r = SLOT_0;
        endcase
        return r;
    endfunction

    function automatic t_slot slot_prev(t_slot s);
        t_slot r;
        case (s)
            SLOT_1:  r = SLOT_0;
            SLOT_2:  r = SLOT_1;
            default: r = SLOT_2;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(t_slot s, logic [POS_W-1:0] c);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_SIDE)) + ADDR_W'(c);
        return a;
    endfunction

endpackage

// ===== hdl/slmc_row_ram.sv =====
module slmc_row_ram (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [slmc_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [slmc_pkg::DATA_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [slmc_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [slmc_pkg::DATA_W-1:0] o_rd_data
);

    logic [slmc_pkg::DATA_W-1:0] r_mem [slmc_pkg::DEPTH];
    logic [slmc_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/slmc_nbr_scan.sv =====
module slmc_nbr_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  slmc_pkg::t_scan_req         i_req,
    output logic                        o_req_ready,
    output logic                        o_rd_en,
    output logic [slmc_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [slmc_pkg::DATA_W-1:0] i_rd_data,
    output slmc_pkg::t_scan_res         o_res,
    input  logic                        i_res_ack
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAIL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    localparam logic [3:0] K_LAST = 4'd8;

    t_state                      r_state;
    logic [3:0]                  r_k;
    slmc_pkg::t_scan_req         r_req;
    logic                        r_tag_v;
    logic                        r_tag_ctr;
    logic [slmc_pkg::DATA_W-1:0] r_me;
    logic                        r_flag;

    logic                        dr_m, dr_p, dc_m, dc_p;
    logic                        in_range;
    slmc_pkg::t_slot             rd_slot;
    logic [slmc_pkg::POS_W-1:0]  rd_col;

    // offset order: center first, then the eight neighbors
    always_comb begin
        dr_m = 1'b0;
        dr_p = 1'b0;
        dc_m = 1'b0;
        dc_p = 1'b0;
        unique case (r_k)
            4'd1: begin dr_m = 1'b1; dc_m = 1'b1; end
            4'd2: begin dr_m = 1'b1; end
            4'd3: begin dr_m = 1'b1; dc_p = 1'b1; end
            4'd4: begin dc_m = 1'b1; end
            4'd5: begin dc_p = 1'b1; end
            4'd6: begin dr_p = 1'b1; dc_m = 1'b1; end
            4'd7: begin dr_p = 1'b1; end
            4'd8: begin dr_p = 1'b1; dc_p = 1'b1; end
            default: begin end
        endcase
    end

    always_comb begin
        rd_slot = dr_m ? slmc_pkg::slot_prev(r_req.slot) :
                  dr_p ? slmc_pkg::slot_next(r_req.slot) : r_req.slot;
        rd_col  = dc_m ? r_req.col - slmc_pkg::POS_W'(1) :
                  dc_p ? r_req.col + slmc_pkg::POS_W'(1) : r_req.col;
        in_range = !(dr_m && r_req.row == '0) && !(dr_p && r_req.row == r_req.n_m1)
                && !(dc_m && r_req.col == '0) && !(dc_p && r_req.col == r_req.n_m1);
    end

    assign o_rd_en     = (r_state == S_SCAN) && in_range;
    assign o_rd_addr   = slmc_pkg::mem_addr(rd_slot, rd_col);
    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_tag_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_tag_v <= 1'b0;
                    if (i_req_valid) begin
                        r_k     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_tag_v <= in_range;
                    r_k     <= r_k + 4'd1;
                    if (r_k == K_LAST) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_tag_v <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_tag_v <= 1'b0;
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_tag_v <= 1'b0;
                end
            endcase
        end
    end

    // payload side: request copy and compare against returning read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_req  <= i_req;
            r_flag <= 1'b1;
        end else if (r_tag_v) begin
            if (r_tag_ctr) begin
                r_me <= i_rd_data;
            end else if (!($signed(r_me) > $signed(i_rd_data))) begin
                r_flag <= 1'b0;
            end
        end
        if (r_state == S_SCAN) begin
            r_tag_ctr <= (r_k == 4'd0);
        end
    end

    always_comb begin
        o_res.valid = (r_state == S_DONE);
        o_res.row   = r_req.row;
        o_res.col   = r_req.col;
        o_res.value = r_me;
        o_res.flag  = r_flag;
        o_res.last  = r_req.last;
    end

endmodule

// ===== hdl/strict_local_maximum_counter_core.sv =====
// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+------------------------------------
// input    | in        | i_in_valid / o_in_ready     | i_element_value
// result   | out       | o_out_valid / i_out_ready   | o_row_index, o_column_index,
//          |           |                             | o_decided_value, o_is_local_max,
//          |           |                             | o_maxima_so_far, o_frame_done
// config   | in        | i_cfg_valid / o_cfg_ready   | i_matrix_size
//
// an input beat is written to the row memory; a beat that decides nothing
// is done then. each decided element costs up to nine reads of its neighborhood
// through the one read port, then a tail state, a hand-off state and a restart state.
// reset is synchronous, active low; the row memory has no reset and needs no clearing.
// input stalls while decisions of the previous beat are pending; the result register
// lets the last decision wait for the sink while the next input beat is taken.
module strict_local_maximum_counter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [15:0]           i_element_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [4:0]                   o_row_index,
    output logic [4:0]                   o_column_index,
    output logic signed [15:0]           o_decided_value,
    output logic                         o_is_local_max,
    output logic [10:0]                  o_maxima_so_far,
    output logic                         o_frame_done,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [5:0]                   i_matrix_size
);

    localparam int POS_W = slmc_pkg::POS_W;

    // frame position and size
    logic [POS_W-1:0]           r_n_m1;
    logic [POS_W-1:0]           r_row;
    logic [POS_W-1:0]           r_col;
    slmc_pkg::t_slot            r_slot;
    logic [slmc_pkg::CNT_W-1:0] r_count;
    logic [slmc_pkg::CNT_W-1:0] n_count;

    // position of the beat whose decisions are pending
    logic [POS_W-1:0]           r_it_row;
    logic [POS_W-1:0]           r_it_col;
    slmc_pkg::t_slot            r_it_slot;

    // pending decisions: diagonal-behind, row end, frame flush
    logic                       r_job_a;
    logic                       r_job_b;
    logic                       r_job_f;
    logic [POS_W-1:0]           r_fcol;

    logic                       in_beat;
    logic                       last_pos;
    logic [POS_W-1:0]           cfg_n_m1;

    slmc_pkg::t_scan_req        scan_req;
    logic                       scan_req_valid;
    logic                       scan_ready;
    slmc_pkg::t_scan_res        scan_res;
    logic                       res_ack;

    logic                       rd_en;
    logic [slmc_pkg::ADDR_W-1:0] rd_addr;
    logic [slmc_pkg::DATA_W-1:0] rd_data;

    // result register
    logic                       r_out_valid;
    logic [POS_W-1:0]           r_o_row;
    logic [POS_W-1:0]           r_o_col;
    logic [slmc_pkg::DATA_W-1:0] r_o_value;
    logic                       r_o_flag;
    logic [slmc_pkg::CNT_W-1:0] r_o_count;
    logic                       r_o_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !(r_job_a || r_job_b || r_job_f) && scan_ready;
    assign in_beat     = i_in_valid && o_in_ready;
    assign last_pos    = (r_row == r_n_m1) && (r_col == r_n_m1);

    // size 0 acts as 1, anything above the row capacity as the capacity
    always_comb begin
        if (i_matrix_size == '0) begin
            cfg_n_m1 = '0;
        end else if (i_matrix_size > slmc_pkg::SIZE_W'(slmc_pkg::MAX_SIDE)) begin
            cfg_n_m1 = POS_W'(slmc_pkg::MAX_SIDE - 1);
        end else begin
            cfg_n_m1 = POS_W'(i_matrix_size - slmc_pkg::SIZE_W'(1));
        end
    end

    slmc_row_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_beat),
        .i_wr_addr (slmc_pkg::mem_addr(r_slot, r_col)),
        .i_wr_data (i_element_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // pick the next pending decision, in raster order
    always_comb begin
        scan_req      = '0;
        scan_req.n_m1 = r_n_m1;
        if (r_job_a) begin
            scan_req.row  = r_it_row - POS_W'(1);
            scan_req.slot = slmc_pkg::slot_prev(r_it_slot);
            scan_req.col  = r_it_col - POS_W'(1);
        end else if (r_job_b) begin
            scan_req.row  = r_it_row - POS_W'(1);
            scan_req.slot = slmc_pkg::slot_prev(r_it_slot);
            scan_req.col  = r_n_m1;
        end else begin
            scan_req.row  = r_it_row;
            scan_req.slot = r_it_slot;
            scan_req.col  = r_fcol;
            scan_req.last = (r_fcol == r_n_m1);
        end
    end

    assign scan_req_valid = r_job_a || r_job_b || r_job_f;

    slmc_nbr_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (scan_req_valid),
        .i_req       (scan_req),
        .o_req_ready (scan_ready),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res       (scan_res),
        .i_res_ack   (res_ack)
    );

    // a decision moves into the result register once that register is free
    assign res_ack = scan_res.valid && (!r_out_valid || i_out_ready);

    // running count saturates at its maximum
    always_comb begin
        n_count = r_count;
        if (scan_res.flag && r_count != '1) begin
            n_count = r_count + slmc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_m1  <= POS_W'(slmc_pkg::SIZE_RESET - 1);
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= slmc_pkg::SLOT_0;
            r_count <= '0;
            r_job_a <= 1'b0;
            r_job_b <= 1'b0;
            r_job_f <= 1'b0;
            r_fcol  <= '0;
        end else begin
            if (i_cfg_valid) begin
                // a size write restarts the frame
                r_n_m1  <= cfg_n_m1;
                r_row   <= '0;
                r_col   <= '0;
                r_slot  <= slmc_pkg::SLOT_0;
                r_count <= '0;
            end else begin
                if (in_beat) begin
                    r_job_a <= (r_row != '0) && (r_col != '0);
                    r_job_b <= (r_row != '0) && (r_col == r_n_m1);
                    r_job_f <= last_pos;
                    r_fcol  <= '0;
                    if (last_pos) begin
                        r_row  <= '0;
                        r_col  <= '0;
                        r_slot <= slmc_pkg::SLOT_0;
                    end else if (r_col == r_n_m1) begin
                        r_col  <= '0;
                        r_row  <= r_row + POS_W'(1);
                        r_slot <= slmc_pkg::slot_next(r_slot);
                    end else begin
                        r_col <= r_col + POS_W'(1);
                    end
                end else if (scan_req_valid && scan_ready) begin
                    if (r_job_a) begin
                        r_job_a <= 1'b0;
                    end else if (r_job_b) begin
                        r_job_b <= 1'b0;
                    end else begin
                        r_fcol <= r_fcol + POS_W'(1);
                        if (r_fcol == r_n_m1) begin
                            r_job_f <= 1'b0;
                        end
                    end
                end
                if (res_ack) begin
                    r_count <= scan_res.last ? '0 : n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_it_row  <= r_row;
            r_it_col  <= r_col;
            r_it_slot <= r_slot;
        end
    end

    // output register: valid is control, payload loads on hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_o_row   <= scan_res.row;
            r_o_col   <= scan_res.col;
            r_o_value <= scan_res.value;
            r_o_flag  <= scan_res.flag;
            r_o_count <= n_count;
            r_o_last  <= scan_res.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_row_index     = r_o_row;
    assign o_column_index  = r_o_col;
    assign o_decided_value = $signed(r_o_value);
    assign o_is_local_max  = r_o_flag;
    assign o_maxima_so_far = r_o_count;
    assign o_frame_done    = r_o_last;

`ifndef SYNTHESIS
    // the frame-end result always sits on the diagonal corner
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_row_index == o_column_index))
        else $error("frame end result not at the last position");

    // a maximum is always counted
    a_max_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_local_max) |-> (o_maxima_so_far != '0))
        else $error("local maximum with zero count");

    // the count restarts after the frame-end hand-off
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_ack && scan_res.last) |=> (r_count == '0))
        else $error("count not cleared at frame end");

    // no new input beat while a decision is still being worked on
    a_in_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_res.valid || rd_en) |-> !in_beat)
        else $error("input accepted during a neighborhood scan");
`endif

endmodule

// ===== sim/slmc_result_checker.sv =====
module slmc_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [15:0] i_element_value,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [5:0]         i_matrix_size,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [4:0]         i_row_index,
    input  logic [4:0]         i_column_index,
    input  logic signed [15:0] i_decided_value,
    input  logic               i_is_local_max,
    input  logic [10:0]        i_maxima_so_far,
    input  logic               i_frame_done,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int COUNT_MAX = 2047;

    typedef struct packed {
        logic [slmc_pkg::POS_W-1:0]         row;
        logic [slmc_pkg::POS_W-1:0]         col;
        logic signed [slmc_pkg::DATA_W-1:0] value;
        logic                               flag;
        logic [slmc_pkg::CNT_W-1:0]         count;
        logic                               done;
    } t_decision;

    logic signed [slmc_pkg::DATA_W-1:0] grid [0:slmc_pkg::DEPTH-1];
    logic [slmc_pkg::SIZE_W-1:0]        side_reg = slmc_pkg::SIZE_W'(slmc_pkg::SIZE_RESET);
    int                                 pos_row = 0;
    int                                 pos_col = 0;
    int                                 maxima = 0;
    int                                 mismatches = 0;
    t_decision                          decisions_q [$];

    function automatic logic signed [slmc_pkg::DATA_W-1:0] grid_at(int r, int c);
        return grid[(r % 3) * slmc_pkg::MAX_SIDE + c];
    endfunction

    // strict compare against every neighbor inside the matrix
    function automatic void decide(int r, int c, int n, bit done);
        t_decision                          d;
        logic signed [slmc_pkg::DATA_W-1:0] me;
        bit                                 flag;
        me = grid_at(r, c);
        flag = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0) begin
                    if (r + dr < n && c + dc < n) begin
                        if (me <= grid_at(r + dr, c + dc))
                            flag = 1'b0;
                    end
                end
            end
        end
        if (flag && maxima < COUNT_MAX)
            maxima++;
        d.row   = slmc_pkg::POS_W'(r);
        d.col   = slmc_pkg::POS_W'(c);
        d.value = me;
        d.flag  = flag;
        d.count = slmc_pkg::CNT_W'(maxima);
        d.done  = done;
        decisions_q.push_back(d);
    endfunction

    always @(posedge i_clk) begin
        t_decision got;
        t_decision want;
        int        n;
        int        r;
        int        c;
        if (!i_rst_n) begin
            side_reg = slmc_pkg::SIZE_W'(slmc_pkg::SIZE_RESET);
            pos_row  = 0;
            pos_col  = 0;
            maxima   = 0;
            decisions_q.delete();
        end else begin
            // a size write restarts the frame
            if (i_cfg_valid && i_cfg_ready) begin
                side_reg = i_matrix_size;
                pos_row  = 0;
                pos_col  = 0;
                maxima   = 0;
            end
            if (i_in_valid && i_in_ready) begin
                n = (side_reg == 0) ? 1 :
                    (side_reg > slmc_pkg::MAX_SIDE) ? slmc_pkg::MAX_SIDE : int'(side_reg);
                r = pos_row;
                c = pos_col;
                if (r >= n || c >= n) begin
                    r = 0;
                    c = 0;
                    maxima = 0;
                end
                grid[(r % 3) * slmc_pkg::MAX_SIDE + c] = i_element_value;
                if (r >= 1) begin
                    if (c >= 1)
                        decide(r - 1, c - 1, n, 1'b0);
                    if (c == n - 1)
                        decide(r - 1, n - 1, n, 1'b0);
                end
                if (r == n - 1 && c == n - 1) begin
                    // last element flushes the final row
                    for (int j = 0; j < n; j++)
                        decide(r, j, n, j == n - 1);
                    pos_row = 0;
                    pos_col = 0;
                    maxima  = 0;
                end else if (c + 1 >= n) begin
                    pos_col = 0;
                    pos_row = r + 1;
                end else begin
                    pos_col = c + 1;
                    pos_row = r;
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_row_index, i_column_index, i_decided_value, i_is_local_max,
                       i_maxima_so_far, i_frame_done};
                if (decisions_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected beat: row %0d col %0d value %0d flag %0d",
                                  " count %0d done %0d"},
                                 got.row, got.col, got.value, got.flag, got.count, got.done);
                end else begin
                    want = decisions_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected row %0d col %0d value %0d flag %0d count %0d",
                                      " done %0d, got row %0d col %0d value %0d flag %0d count %0d",
                                      " done %0d"},
                                     want.row, want.col, want.value, want.flag, want.count,
                                     want.done, got.row, got.col, got.value, got.flag, got.count,
                                     got.done);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= decisions_q.size();
    end

endmodule

// ===== sim/tb_strict_local_maximum_counter_core.sv =====
module tb_strict_local_maximum_counter_core;

    // long receiver hold-off so the block backs up and stalls its input
    localparam int HOLD_CYCLES   = 400;
    // quiet time after the last result before a size write or the verdict
    localparam int SETTLE_CYCLES = 40;
    // rough item count per random phase
    localparam int PHASE_ITEMS   = 65;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_element_value;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [4:0]         o_row_index;
    logic [4:0]         o_column_index;
    logic signed [15:0] o_decided_value;
    logic               o_is_local_max;
    logic [10:0]        o_maxima_so_far;
    logic               o_frame_done;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [5:0]         i_matrix_size;

    // idle percentages for each side, changed per phase
    int send_idle_pct = 29;
    int recv_idle_pct = 65;

    // hold-off handshake between stimulus and the receiver process
    int hold_request = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    int fail_count;
    int pending;

    // last size written and whether a frame was left unfinished
    logic [5:0] size_written;
    bit         frame_open;

    strict_local_maximum_counter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_decided_value (o_decided_value),
        .o_is_local_max  (o_is_local_max),
        .o_maxima_so_far (o_maxima_so_far),
        .o_frame_done    (o_frame_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_matrix_size   (i_matrix_size)
    );

    // predicts every decision and compares the result beats
    slmc_result_checker decision_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_matrix_size   (i_matrix_size),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_row_index     (o_row_index),
        .i_column_index  (o_column_index),
        .i_decided_value (o_decided_value),
        .i_is_local_max  (o_is_local_max),
        .i_maxima_so_far (o_maxima_so_far),
        .i_frame_done    (o_frame_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random ready, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_seen != hold_request) begin
            hold_seen   <= hold_request;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // element values: full range, tiny range for ties, extremes, small signed spread
    function automatic logic signed [15:0] pick_value();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh7fff;
                    1:       v = 16'sh8000;
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
            default: v = 16'($urandom_range(0, 255)) - 16'sd128;
        endcase
        return v;
    endfunction

    // one input beat, with random gaps before it; valid stays up between back-to-back beats
    task automatic push_element(input logic signed [15:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // size writes only happen with the block idle
    task automatic write_size(input logic [5:0] sz);
        drain();
        i_cfg_valid   <= 1'b1;
        i_matrix_size <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        size_written = sz;
        frame_open   = 1'b0;
    endtask

    // frames of random size and content; big sizes only get a few rows
    task automatic random_phase(input int goal, input logic [5:0] first_size, input bit squeeze);
        int         sent;
        int         n;
        int         count;
        int         k;
        logic [5:0] sz;
        sent = 0;
        sz   = first_size;
        while (sent < goal) begin
            if (sz != size_written || frame_open || $urandom_range(0, 3) == 0)
                write_size(sz);
            if (squeeze) begin
                hold_request <= hold_request + 1;
                squeeze = 1'b0;
            end
            n = (sz == 0) ? 1 :
                (sz > slmc_pkg::MAX_SIDE) ? slmc_pkg::MAX_SIDE : int'(sz);
            count      = n * n;
            frame_open = 1'b0;
            if (n > 12) begin
                // row 0 and part of row 1, up to three full rows, then a restart
                count      = $urandom_range(n + 2, 3 * n);
                frame_open = 1'b1;
            end else if (n > 1 && $urandom_range(0, 9) == 0) begin
                // broken frame, cut short by the next size write
                count      = $urandom_range(1, n * n - 1);
                frame_open = 1'b1;
            end
            repeat (count) push_element(pick_value());
            sent += count;
            k = $urandom_range(0, 99);
            if (k < 6) begin
                case ($urandom_range(0, 2))
                    0:       sz = 6'd32;
                    1:       sz = 6'd33;
                    default: sz = 6'd63;
                endcase
            end else if (k < 12) begin
                sz = 6'd0;
            end else if (k < 85) begin
                sz = 6'($urandom_range(1, 6));
            end else begin
                sz = 6'($urandom_range(7, 12));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_element_value <= '0;
        i_cfg_valid     <= 1'b0;
        i_matrix_size   <= '0;
        size_written = 6'(slmc_pkg::SIZE_RESET);
        frame_open   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size: a full row and two more, so (0,0) is decided with an 8-wide row
        repeat (10) push_element(pick_value());

        // size write in the middle of a frame restarts it; single element always counts
        write_size(6'd1);
        push_element(16'sh7fff);
        push_element(16'sh8000);

        // size zero behaves as one
        write_size(6'd0);
        push_element(16'sd0);

        // two by two with equal diagonal peaks: no strict maximum
        write_size(6'd2);
        push_element(16'sh8000);
        push_element(16'sh7fff);
        push_element(16'sh7fff);
        push_element(16'sh8000);

        // three by three plateau with one raised center
        write_size(6'd3);
        for (int j = 0; j < 9; j++)
            push_element((j == 4) ? 16'sd100 : 16'sd7);

        // sender idles lightly, receiver heavily
        random_phase(PHASE_ITEMS, 6'd63, 1'b0);

        // sender idles heavily, receiver lightly
        send_idle_pct <= 65;
        recv_idle_pct <= 29;
        random_phase(PHASE_ITEMS, 6'd33, 1'b0);

        // no idling, with one long receiver hold-off at the start
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        random_phase(PHASE_ITEMS, 6'd32, 1'b1);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
